/* sv/ofcw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, band table and codes for the oscillator control word converter.
// No dependencies; every other file imports this package.
package ofcw_pkg;

	localparam int FreqW   = 27;
	localparam int CodeW   = 10;
	localparam int OctW    = 4;
	localparam int WordW   = 16;
	localparam int CfgW    = 2;
	localparam int NumBands = 16;

	localparam int QueueDepthDef = 2;

	// Register index codes on the configuration port (paddr[2]).
	localparam logic RegLowCfg = 1'b0;

	// Job kinds decided by the front end.
	localparam logic [1:0] KindDirect = 2'd0;
	localparam logic [1:0] KindZero   = 2'd1;
	localparam logic [1:0] KindCalc   = 2'd2;

	localparam logic [11:0]      BaseFreq  = 12'd2078;
	localparam int               ShiftBase = 10;
	localparam logic [CodeW-1:0] CodeMax   = 10'd1023;
	// Quotient bits needed to see anything above CodeMax.
	localparam int               DivSteps  = CodeW + 1;

	// Band bounds, lower inclusive and upper exclusive, indexed by octave.
	localparam logic [FreqW-1:0] BandLow [NumBands] = '{
		27'd1039,    27'd2078,    27'd4156,    27'd8312,
		27'd16620,   27'd33250,   27'd66500,   27'd133000,
		27'd266000,  27'd532000,  27'd1064000, 27'd2128000,
		27'd4256000, 27'd8511000, 27'd17020000, 27'd34050000
	};
	localparam logic [FreqW-1:0] BandHigh [NumBands] = '{
		27'd2076,    27'd4152,    27'd8304,    27'd16610,
		27'd33220,   27'd66430,   27'd132900,  27'd265700,
		27'd531400,  27'd1063000, 27'd2126000, 27'd4252000,
		27'd8503000, 27'd17010000, 27'd34010000, 27'd68030000
	};

	typedef struct packed {
		logic             operation;
		logic [FreqW-1:0] frequency_hz;
		logic [CodeW-1:0] direct_code;
		logic [OctW-1:0]  direct_octave;
	} in_item_t;

	typedef struct packed {
		logic [WordW-1:0] control_word;
		logic [OctW-1:0]  octave_used;
		logic [CodeW-1:0] code_used;
		logic             octave_error;
		logic             code_error;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [FreqW-1:0] freq;
		logic [OctW-1:0]  octave;
		logic [CodeW-1:0] code;
		logic             oct_err;
	} job_t;

endpackage

/* sv/ofcw_front.sv */
`timescale 1ns / 1ps
// Front end: takes a command beat, finds the octave band and classifies the job.
// Depends on ofcw_pkg.
module ofcw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ofcw_pkg::in_item_t cmd,
	input  logic              q_full,
	output logic              busy,
	output logic              push,
	output ofcw_pkg::job_t    job,
	output logic [ofcw_pkg::OctW-1:0] held_octave
);
	import ofcw_pkg::*;

	logic [OctW-1:0] held_q;
	logic            hit;
	logic [OctW-1:0] band;

	assign busy = q_full;
	assign push = start & ~q_full;
	assign held_octave = held_q;

	// Highest matching band wins; bands do not overlap anyway.
	always_comb begin
		hit  = 1'b0;
		band = '0;
		for (int i = 0; i < NumBands; i++) begin
			if (cmd.frequency_hz >= BandLow[i] && cmd.frequency_hz < BandHigh[i]) begin
				hit  = 1'b1;
				band = OctW'(i);
			end
		end
	end

	always_comb begin
		job.freq    = cmd.frequency_hz;
		job.code    = cmd.direct_code;
		job.oct_err = ~cmd.operation & ~hit;
		if (cmd.operation) begin
			job.kind   = KindDirect;
			job.octave = cmd.direct_octave;
		end else begin
			job.kind   = (cmd.frequency_hz == '0) ? KindZero : KindCalc;
			job.octave = hit ? band : held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (push) begin
			held_q <= job.octave;
		end
	end

endmodule

/* sv/ofcw_queue.sv */
`timescale 1ns / 1ps
// Small register FIFO of jobs between front end and engine.
// Depends on ofcw_pkg.
module ofcw_queue #(
	parameter int DEPTH = ofcw_pkg::QueueDepthDef  // 2 or more
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ofcw_pkg::job_t din,
	input  logic           pop,
	output ofcw_pkg::job_t dout,
	output logic           empty,
	output logic           full
);
	import ofcw_pkg::*;

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CntW'(DEPTH));
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/ofcw_engine.sv */
`timescale 1ns / 1ps
// Back end: pops a job, computes the rounded code with a restoring divider
// and strobes the packed result. Depends on ofcw_pkg.
module ofcw_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ofcw_pkg::job_t            job,
	input  logic                      empty,
	input  logic [ofcw_pkg::CfgW-1:0] low_cfg,
	output logic                      pop,
	output logic                      result_valid,
	output ofcw_pkg::out_item_t       result
);
	import ofcw_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIFF = 3'd1;
	localparam logic [2:0] S_MAG  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_OVF  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;

	localparam int VW = FreqW + 12;  // signed difference 2048*f - N
	localparam int RW = VW + 1;      // remainder 2*|v| + f

	logic [2:0]       state_q;
	logic [FreqW-1:0] f_q;
	logic [OctW-1:0]  oct_q;
	logic             oerr_q;
	logic [VW-1:0]    v_q;
	logic             neg_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    dsh_q;
	logic [DivSteps-1:0] quo_q;
	logic [3:0]       step_q;
	logic             done_q;
	out_item_t        res_q;

	logic [VW-1:0]       n_val;
	logic [VW-1:0]       v_neg;
	logic                ge;
	logic [DivSteps-1:0] qn;
	logic                ovf_now;
	logic [CodeW-1:0]    fin_code;
	logic                fin_cerr;
	logic [CodeW-1:0]    sat_code;

	function automatic out_item_t pack_result(logic [OctW-1:0] oct, logic [CodeW-1:0] code,
	                                          logic oerr, logic cerr, logic [CfgW-1:0] cfg);
		out_item_t r;
		r.control_word = {oct, code, cfg};
		r.octave_used  = oct;
		r.code_used    = code;
		r.octave_error = oerr;
		r.code_error   = cerr;
		return r;
	endfunction

	assign pop          = (state_q == S_IDLE) & ~empty;
	assign result_valid = done_q;
	assign result       = res_q;

	always_comb begin
		n_val   = VW'(BaseFreq) << (ShiftBase + int'(oct_q));
		v_neg   = -v_q;
		ge      = (rem_q >= dsh_q);
		qn      = {quo_q[DivSteps-2:0], ge};
		ovf_now = (rem_q >= {1'b0, f_q, 12'b0});
		sat_code = neg_q ? '0 : CodeMax;
		if (neg_q) begin
			fin_code = '0;
			fin_cerr = (qn != '0);
		end else if (qn > DivSteps'(CodeMax)) begin
			fin_code = CodeMax;
			fin_cerr = 1'b1;
		end else begin
			fin_code = qn[CodeW-1:0];
			fin_cerr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			f_q     <= '0;
			oct_q   <= '0;
			oerr_q  <= 1'b0;
			v_q     <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			dsh_q   <= '0;
			quo_q   <= '0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						f_q    <= job.freq;
						oct_q  <= job.octave;
						oerr_q <= job.oct_err;
						case (job.kind)
							KindDirect: begin
								res_q  <= pack_result(job.octave, job.code, 1'b0, 1'b0, low_cfg);
								done_q <= 1'b1;
							end
							KindZero: begin
								res_q  <= pack_result(job.octave, '0, job.oct_err, 1'b1, low_cfg);
								done_q <= 1'b1;
							end
							default: begin
								state_q <= S_DIFF;
							end
						endcase
					end
				end
				S_DIFF: begin
					v_q     <= {1'b0, f_q, 11'b0} - n_val;
					state_q <= S_MAG;
				end
				S_MAG: begin
					neg_q   <= v_q[VW-1];
					rem_q   <= {2'b0, (v_q[VW-1] ? v_neg[VW-2:0] : v_q[VW-2:0])};
					state_q <= S_SUM;
				end
				S_SUM: begin
					rem_q   <= {rem_q[RW-2:0], 1'b0} + RW'(f_q);
					dsh_q   <= {2'b0, f_q, 11'b0};
					state_q <= S_OVF;
				end
				S_OVF: begin
					quo_q  <= '0;
					step_q <= 4'(DivSteps - 1);
					if (ovf_now) begin
						// Quotient is far beyond the code range: saturate now.
						res_q   <= pack_result(oct_q, sat_code, oerr_q, 1'b1, low_cfg);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q  <= qn;
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						res_q   <= pack_result(oct_q, fin_code, oerr_q, fin_cerr, low_cfg);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/oscillator_freq_to_control_word.sv */
`timescale 1ns / 1ps
// Top level of the oscillator control word converter: APB register, front end,
// job queue and divider engine. Depends on ofcw_pkg and the ofcw_* modules.
//
// Issue a command by raising start with cmd while busy is low; that edge takes the
// beat. Each command gives exactly one result beat, shown on result for one cycle
// with result_valid high; the receiver cannot stall, so sample it on that cycle.
// The front end picks the octave from the band table and updates the held octave
// in the same cycle, then parks the job in a QUEUE_DEPTH-entry queue; busy is high
// only while that queue is full. The engine pops one job at a time. Direct-mode
// commands and zero frequency are packed and strobed as soon as they are popped;
// a computed code passes the pop into the engine, three set-up states that form
// 2*|2048*f - N| + f, one overflow check that saturates a quotient far out of
// range at once, and the 11-step restoring divider (one quotient bit per cycle).
// The engine takes a new direct or zero job every cycle while the queue holds
// one, but takes no new job before a computed code is done. The low configuration
// bits sit at byte address 0 and are sampled when the result is formed; write
// them only while idle.
module oscillator_freq_to_control_word #(
	parameter int QUEUE_DEPTH = ofcw_pkg::QueueDepthDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	input  ofcw_pkg::in_item_t   cmd,
	output logic                 busy,
	// result channel
	output logic                 result_valid,
	output ofcw_pkg::out_item_t  result,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import ofcw_pkg::*;

	logic [CfgW-1:0] low_cfg_q;
	logic            cfg_wr;
	logic            push;
	logic            pop;
	logic            q_empty;
	logic            q_full;
	job_t            job_in;
	job_t            job_out;
	logic [OctW-1:0] held_octave;

	// Register file: one 2-bit register; other addresses read zero and drop writes.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == RegLowCfg);
	assign prdata = (paddr[2] == RegLowCfg) ? {30'b0, low_cfg_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_cfg_q <= '0;
		end else if (cfg_wr) begin
			low_cfg_q <= pwdata[CfgW-1:0];
		end
	end

	// Classify and band-search each command beat.
	ofcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.q_full     (q_full),
		.busy       (busy),
		.push       (push),
		.job        (job_in),
		.held_octave(held_octave)
	);

	// Hold jobs while the engine grinds through a division.
	ofcw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (job_in),
		.pop   (pop),
		.dout  (job_out),
		.empty (q_empty),
		.full  (q_full)
	);

	// Compute the code and pack the word.
	ofcw_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job_out),
		.empty       (q_empty),
		.low_cfg     (low_cfg_q),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

	// A saturated code sits at one of the two range ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.code_error |->
			(result.code_used == '0 || result.code_used == CodeMax))
		else $error("saturated code not at a range end");

	// The word carries the reported octave and code.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.control_word[15:12] == result.octave_used &&
		                  result.control_word[11:2] == result.code_used))
		else $error("control word fields disagree with reported octave and code");

	// A direct command sets the held octave for the next computed command.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.operation |=> held_octave == $past(cmd.direct_octave))
		else $error("held octave not taken from direct command");

endmodule
